[design/subtitle_cue_stream_parser_unit_macros.svh]
// Assertion macros for the subtitle cue stream parser.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef SUBTITLE_CUE_STREAM_PARSER_UNIT_MACROS_SVH
`define SUBTITLE_CUE_STREAM_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SCSP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scsp assertion failed");
// next-cycle implication, checked out of reset
`define SCSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scsp assertion failed");
`else
`define SCSP_ASSERT_NOW(label, clk, rstn, ante, cons)
`define SCSP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[design/scsp_pkg.sv]
// Types and constants for the subtitle cue stream parser.
// No dependencies; imported by subtitle_cue_stream_parser_unit.
package scsp_pkg;

    // line machine modes
    typedef enum logic [1:0] {
        MODE_NUMBER = 2'd0,
        MODE_TIME   = 2'd1,
        MODE_TEXT   = 2'd2
    } mode_t;

    typedef logic [4:0] phase_t;

    // timing line phases
    localparam phase_t PH_ARROW     = 5'd8;
    localparam phase_t PH_SECOND    = 5'd12;
    localparam phase_t PH_LAST_LEAD = 5'd18;
    localparam phase_t PH_LAST_DIG  = 5'd19;
    localparam phase_t PH_LIMIT     = 5'd20;

    // characters of interest
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // width of the millisecond fields on the result word
    localparam int MS_W = 32;

    // expected byte at each position of " --> " after the first space
    function automatic logic [7:0] arrow_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_DASH;
            2'd1:    ch = CH_DASH;
            2'd2:    ch = CH_GT;
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

endpackage

[design/subtitle_cue_stream_parser_unit.sv]
// Subtitle cue stream parser: line machine, time accumulation and result register.
// Depends on scsp_pkg and subtitle_cue_stream_parser_unit_macros.svh.
//
// Usage:
//   Input channel s_*: one file byte per word on s_tdata, s_tuser marks end of
//   stream (the byte is then ignored). Result channel m_*: one text byte or one
//   line end marker per word, each carrying the cue begin and end times in ms.
//   An input word yields zero or one result word.
//   A result is registered and appears on m_* the cycle after its input word is taken.
//   Throughput: one input word per cycle while s_tready is high; all parsing of a byte is done in the
//   cycle it is accepted, with the shift-add time accumulator as the deepest path.
//   The single result register accepts a new word in the same cycle the old one
//   is taken, so s_tready only drops while a result sits unread with m_tready low.
//   Reset (aresetn low, synchronous) empties the result register and puts the
//   line machine in number-line mode with all times at zero. End of stream acts
//   as a final newline and then returns the machine to that same state.
`include "subtitle_cue_stream_parser_unit_macros.svh"

module subtitle_cue_stream_parser_unit
    import scsp_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_tuser,   // [0] kind (1 = end of stream)
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] out_byte, [39:8] begin_ms, [71:40] end_ms
    output logic [0:0]  m_tuser    // [0] line_end
);

    typedef logic [TIME_BITS-1:0] time_t;

    // line machine state
    mode_t      mode_reg,   mode_next;
    phase_t     phase_reg,  phase_next;
    logic       rej_reg,    rej_next;
    logic       alld_reg,   alld_next;
    logic       hasb_reg,   hasb_next;
    time_t      fv_reg,     fv_next;
    time_t      acc_reg,    acc_next;
    time_t      begin_reg,  begin_next;
    time_t      end_reg,    end_next;

    // result register
    logic        m_valid_reg;
    logic [7:0]  obyte_reg;
    logic [MS_W-1:0] obegin_reg;
    logic [MS_W-1:0] oend_reg;
    logic        olast_reg;

    logic        s_fire;
    logic        m_fire;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        emit_last;

    logic [7:0]  ch;
    logic        is_eos;
    logic        is_digit;
    time_t       digit_val;

    // field decode of the timing phase
    logic        second_half;
    logic [2:0]  q;
    logic [1:0]  fld;
    logic        dig;
    phase_t      sep_phase;

    time_t       acc60;
    time_t       acc1000;
    time_t       commit_val;
    time_t       fv10;

    logic [MS_W-1:0] begin_ms;
    logic [MS_W-1:0] end_ms;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_valid_reg && m_tready;
    assign s_tready = !m_valid_reg || m_tready;

    assign ch = s_tdata;
    assign is_eos = s_tuser[0];
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit_val = TIME_BITS'(4'(ch - CH_ZERO));

    assign second_half = (phase_reg >= PH_SECOND);
    assign q = second_half ? 3'(phase_reg - PH_SECOND) : phase_reg[2:0];
    assign fld = q[2:1];
    assign dig = q[0];
    assign sep_phase = {4'(phase_reg[4:1] + 4'd1), 1'b0};

    // fold the finished field into the accumulator (x60 or x1000 by shift-add)
    assign acc60   = (acc_reg << 6) - (acc_reg << 2);
    assign acc1000 = (acc_reg << 10) - (acc_reg << 5) + (acc_reg << 3);
    assign fv10    = (fv_reg << 3) + (fv_reg << 1);

    always_comb begin
        case (fld)
            2'd0:    commit_val = fv_reg;
            2'd1:    commit_val = acc60 + fv_reg;
            2'd2:    commit_val = acc60 + fv_reg;
            default: commit_val = acc1000 + fv_reg;
        endcase
    end

    // next state and result for the accepted word
    always_comb begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        rej_next   = rej_reg;
        alld_next  = alld_reg;
        hasb_next  = hasb_reg;
        fv_next    = fv_reg;
        acc_next   = acc_reg;
        begin_next = begin_reg;
        end_next   = end_reg;
        emit       = 1'b0;
        emit_byte  = ch;
        emit_last  = 1'b0;

        if (is_eos || ch == CH_LF) begin
            // close the line
            case (mode_reg)
                MODE_TIME: begin
                    if (!rej_reg && (phase_reg == PH_LAST_LEAD || phase_reg == PH_LAST_DIG)) begin
                        end_next  = commit_val;
                        mode_next = MODE_TEXT;
                    end
                end
                MODE_TEXT: begin
                    if (hasb_reg) begin
                        emit      = 1'b1;
                        emit_byte = 8'd0;
                        emit_last = 1'b1;
                        hasb_next = 1'b0;
                    end else begin
                        mode_next = MODE_NUMBER;
                    end
                end
                default: begin
                    mode_next = alld_reg ? MODE_TIME : MODE_NUMBER;
                end
            endcase
            phase_next = '0;
            rej_next   = 1'b0;
            alld_next  = 1'b1;
            fv_next    = '0;
            acc_next   = '0;
            // end of stream: back to the reset state
            if (is_eos) begin
                mode_next  = MODE_NUMBER;
                hasb_next  = 1'b0;
                begin_next = '0;
                end_next   = '0;
            end
        end else if (ch != CH_CR) begin
            case (mode_reg)
                MODE_TIME: begin
                    if (!rej_reg) begin
                        if (phase_reg >= PH_ARROW && phase_reg < PH_SECOND) begin
                            // match the arrow
                            if (ch == arrow_char(phase_reg[1:0])) begin
                                phase_next = phase_reg + 5'd1;
                            end else begin
                                rej_next = 1'b1;
                            end
                        end else if (phase_reg >= PH_LIMIT) begin
                            rej_next = 1'b1;
                        end else if (is_digit) begin
                            fv_next    = dig ? fv10 + digit_val : digit_val;
                            phase_next = phase_reg | 5'd1;
                        end else if (ch == CH_SPACE) begin
                            // leading spaces skip; a space after the first ms opens the arrow
                            if (dig) begin
                                if (fld == 2'd3 && !second_half) begin
                                    acc_next   = commit_val;
                                    begin_next = commit_val;
                                    phase_next = PH_ARROW;
                                end else begin
                                    rej_next = 1'b1;
                                end
                            end
                        end else if ((fld < 2'd2 && ch == CH_COLON) ||
                                     (fld == 2'd2 && ch == CH_COMMA)) begin
                            acc_next   = commit_val;
                            fv_next    = '0;
                            phase_next = sep_phase;
                        end else begin
                            rej_next = 1'b1;
                        end
                    end
                end
                MODE_TEXT: begin
                    hasb_next = 1'b1;
                    emit      = 1'b1;
                end
                default: begin
                    if (!is_digit) begin
                        alld_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NUMBER;
            phase_reg <= '0;
            rej_reg   <= 1'b0;
            alld_reg  <= 1'b1;
            hasb_reg  <= 1'b0;
            fv_reg    <= '0;
            acc_reg   <= '0;
            begin_reg <= '0;
            end_reg   <= '0;
        end else if (s_fire) begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            rej_reg   <= rej_next;
            alld_reg  <= alld_next;
            hasb_reg  <= hasb_next;
            fv_reg    <= fv_next;
            acc_reg   <= acc_next;
            begin_reg <= begin_next;
            end_reg   <= end_next;
        end
    end

    // fit the cue times to the result field width
    if (TIME_BITS >= MS_W) begin : g_ms_trunc
        assign begin_ms = begin_reg[MS_W-1:0];
        assign end_ms   = end_reg[MS_W-1:0];
    end else begin : g_ms_ext
        assign begin_ms = {{(MS_W-TIME_BITS){1'b0}}, begin_reg};
        assign end_ms   = {{(MS_W-TIME_BITS){1'b0}}, end_reg};
    end

    // result valid: drop when taken, set on a new result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            obyte_reg  <= emit_byte;
            obegin_reg <= begin_ms;
            oend_reg   <= end_ms;
            olast_reg  <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {oend_reg, obegin_reg, obyte_reg};
    assign m_tuser  = olast_reg;

    // checks
    `SCSP_ASSERT_NOW(a_phase_range, aclk, aresetn, 1'b1, phase_reg < PH_LIMIT)
    `SCSP_ASSERT_NOW(a_bytes_only_text, aclk, aresetn, mode_reg != MODE_TEXT, !hasb_reg)
    `SCSP_ASSERT_NOW(a_reject_only_time, aclk, aresetn, mode_reg != MODE_TIME, !rej_reg)
    `SCSP_ASSERT_NEXT(a_eos_resets, aclk, aresetn, s_fire && is_eos, mode_reg == MODE_NUMBER && begin_reg == '0 && end_reg == '0)

endmodule
